// ----- src/pts_pkg.sv -----
// Shared types, codes and constants for the pickup test sequencer.
// No dependencies; used by pts_core and pickup_test_sequencer.
package pts_pkg;

    localparam int POS_W   = 21;
    localparam int MOVE_W  = 22;
    localparam int CNT_W   = 17;
    localparam int LIMIT_W = 16;
    localparam int CFG_W   = 21;
    localparam int CFG_IDX_W = 3;

    localparam int LIFT_UM_DEFAULT = 20000;

    localparam logic [CNT_W-1:0] CNT_MAX = 17'h10000;

    // event codes
    localparam logic [2:0] OP_START_MEAS  = 3'd0;
    localparam logic [2:0] OP_MEAS_RESULT = 3'd1;
    localparam logic [2:0] OP_START_PICK  = 3'd2;
    localparam logic [2:0] OP_STEP_DONE   = 3'd3;
    localparam logic [2:0] OP_RESET       = 3'd4;

    // command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_MOVE  = 3'd1;
    localparam logic [2:0] CMD_VAC   = 3'd2;
    localparam logic [2:0] CMD_MREQ  = 3'd3;
    localparam logic [2:0] CMD_MDONE = 3'd4;
    localparam logic [2:0] CMD_PDONE = 3'd5;
    localparam logic [2:0] CMD_FIN   = 3'd6;

    // test modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_MEAS = 2'd1;
    localparam logic [1:0] MODE_PICK = 2'd2;

    // last motion
    localparam logic [1:0] MV_NONE = 2'd0;
    localparam logic [1:0] MV_XY   = 2'd1;
    localparam logic [1:0] MV_Z    = 2'd2;

    // vacuum lines
    localparam logic VAC_TOOL = 1'b0;
    localparam logic VAC_BASE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_BASE  = 3'd7;

    typedef struct packed {
        logic [CNT_W-1:0] iter;
        logic [1:0]       mode;
        logic [1:0]       motion;
        logic             tool_vac;
        logic             base_vac;
        logic             pick_done;
        logic             lifted;
    } pts_state_t;

    localparam pts_state_t STATE_CLEAR = '{
        iter:      '0,
        mode:      MODE_IDLE,
        motion:    MV_NONE,
        tool_vac:  1'b0,
        base_vac:  1'b1,
        pick_done: 1'b0,
        lifted:    1'b0
    };

    typedef struct packed {
        logic signed [POS_W-1:0] measure_x;
        logic signed [POS_W-1:0] measure_y;
        logic signed [POS_W-1:0] measure_z;
        logic signed [POS_W-1:0] pick_x;
        logic signed [POS_W-1:0] pick_y;
        logic signed [POS_W-1:0] pick_z;
        logic [LIMIT_W-1:0]      iter_limit;
        logic                    use_base_vac;
    } pts_cfg_t;

    typedef struct packed {
        logic [2:0]              operation;
        logic                    measurement_failed;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } pts_item_t;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [MOVE_W-1:0] move_dx;
        logic signed [MOVE_W-1:0] move_dy;
        logic signed [MOVE_W-1:0] move_dz;
        logic                     vacuum_target;
        logic                     logic_fault;
        logic [CNT_W-1:0]         iterations_done;
    } pts_result_t;

    // target minus position, exact in 22 bits
    function automatic logic signed [MOVE_W-1:0] pos_diff(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        return $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    endfunction

endpackage

// ----- src/pickup_test_sequencer.sv -----
// Result path: an accepted request goes through the input register, then its result is written to the result register.
// Throughput: one request per cycle while results are taken; the sequencing state updates in a single stage.
// Stalls: a held result stalls the input once the input register also holds a request.
// Reset: synchronous active-low aresetn clears config to 0, counter to 0, flags to
// idle (baseplate vacuum on) and empties both pipeline registers.
module pickup_test_sequencer #(
    parameter int LIFT_UM = pts_pkg::LIFT_UM_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pts_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // measurement_failed[0], pos_x[21:1], pos_y[42:22], pos_z[63:43]
    input  logic [63:0]                     s_tdata,
    // operation[2:0]
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // move_dx[21:0], move_dy[43:22], move_dz[65:44], vacuum_target[66],
    // logic_fault[67], iterations_done[84:68], zero pad[87:85]
    output logic [87:0]                     m_tdata,
    // command[2:0]
    output logic [2:0]                      m_tuser
);
    import pts_pkg::*;

    pts_cfg_t    cfg_reg;
    pts_state_t  st_reg;
    pts_state_t  st_next;
    pts_item_t   in_reg;
    logic        in_vld_reg;
    pts_result_t res_next;
    pts_result_t res_reg;
    logic        out_vld_reg;
    logic        advance;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MEASURE_X: cfg_reg.measure_x    <= cfg_wdata;
                CFG_MEASURE_Y: cfg_reg.measure_y    <= cfg_wdata;
                CFG_MEASURE_Z: cfg_reg.measure_z    <= cfg_wdata;
                CFG_PICK_X:    cfg_reg.pick_x       <= cfg_wdata;
                CFG_PICK_Y:    cfg_reg.pick_y       <= cfg_wdata;
                CFG_PICK_Z:    cfg_reg.pick_z       <= cfg_wdata;
                CFG_ITER_LIM:  cfg_reg.iter_limit   <= cfg_wdata[LIMIT_W-1:0];
                CFG_USE_BASE:  cfg_reg.use_base_vac <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.operation          <= s_tuser;
            in_reg.measurement_failed <= s_tdata[0];
            in_reg.pos_x              <= s_tdata[21:1];
            in_reg.pos_y              <= s_tdata[42:22];
            in_reg.pos_z              <= s_tdata[63:43];
        end
    end

    pts_core #(
        .LIFT_UM (LIFT_UM)
    ) u_core (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .item    (in_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // sequencing state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= STATE_CLEAR;
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            st_reg      <= st_next;
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance)
            res_reg <= res_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = res_reg.command;
    assign m_tdata  = {3'b000, res_reg.iterations_done, res_reg.logic_fault,
                       res_reg.vacuum_target, res_reg.move_dz, res_reg.move_dy,
                       res_reg.move_dx};

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_tready)
        else $error("input register empty but request not accepted");

    a_fault_only_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.logic_fault |-> res_reg.command == CMD_FIN)
        else $error("logic fault flagged on a non-finish command");

    a_finish_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.command == CMD_FIN |-> res_reg.iterations_done == '0)
        else $error("test finish left a nonzero iteration count");

    a_move_zero_otherwise: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.command != CMD_MOVE |->
            res_reg.move_dx == '0 && res_reg.move_dy == '0 && res_reg.move_dz == '0)
        else $error("move fields nonzero on a non-move command");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.iter[CNT_W-1] |-> st_reg.iter[CNT_W-2:0] == '0)
        else $error("iteration counter passed its saturation value");

    a_state_follows_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg) || !$past(aresetn))
        else $error("sequencing state changed without a processed request");

endmodule

// ----- src/pts_core.sv -----
// Event decode and sequencing logic: next state and command for one event.
// Purely combinational; depends on pts_pkg.
module pts_core #(
    parameter int LIFT_UM = pts_pkg::LIFT_UM_DEFAULT
) (
    input  pts_pkg::pts_state_t  st,
    input  pts_pkg::pts_cfg_t    cfg,
    input  pts_pkg::pts_item_t   item,
    output pts_pkg::pts_state_t  st_next,
    output pts_pkg::pts_result_t res
);
    import pts_pkg::*;

    localparam logic signed [MOVE_W-1:0] LIFT = MOVE_W'(LIFT_UM);

    logic fin;
    logic fin_fault;
    logic over_limit;

    assign over_limit = st.iter > {1'b0, cfg.iter_limit};

    always_comb begin
        st_next   = st;
        res       = '0;
        res.command = CMD_NONE;
        fin       = 1'b0;
        fin_fault = 1'b0;

        unique case (item.operation)
            OP_START_MEAS: begin
                st_next.mode   = MODE_MEAS;
                st_next.motion = MV_Z;
                res.command    = CMD_MOVE;
                res.move_dz    = pos_diff(cfg.measure_z, item.pos_z);
            end
            OP_MEAS_RESULT: begin
                if (item.measurement_failed) begin
                    fin = 1'b1;
                end else begin
                    if (st.iter != CNT_MAX)
                        st_next.iter = st.iter + 1'b1;
                    res.command = CMD_MDONE;
                end
            end
            OP_START_PICK: begin
                if (over_limit) begin
                    fin = 1'b1;
                end else begin
                    st_next.mode      = MODE_PICK;
                    st_next.tool_vac  = 1'b0;
                    st_next.base_vac  = 1'b1;
                    st_next.pick_done = 1'b0;
                    st_next.lifted    = 1'b0;
                    st_next.motion    = MV_XY;
                    res.command       = CMD_MOVE;
                    res.move_dx       = pos_diff(cfg.pick_x, item.pos_x);
                    res.move_dy       = pos_diff(cfg.pick_y, item.pos_y);
                end
            end
            OP_STEP_DONE: begin
                if (over_limit) begin
                    fin = 1'b1;
                end else if (st.mode == MODE_MEAS) begin
                    if (st.motion == MV_Z) begin
                        st_next.motion = MV_XY;
                        res.command    = CMD_MOVE;
                        res.move_dx    = pos_diff(cfg.measure_x, item.pos_x);
                        res.move_dy    = pos_diff(cfg.measure_y, item.pos_y);
                    end else if (st.motion == MV_XY) begin
                        st_next.motion = MV_NONE;
                        res.command    = CMD_MREQ;
                    end else begin
                        fin       = 1'b1;
                        fin_fault = 1'b1;
                    end
                end else if (st.mode != MODE_PICK) begin
                    fin       = 1'b1;
                    fin_fault = 1'b1;
                end else if (st.pick_done) begin
                    // release phase: restore baseplate, drop tool vacuum, report
                    if (st.lifted) begin
                        fin       = 1'b1;
                        fin_fault = 1'b1;
                    end else if (cfg.use_base_vac && !st.base_vac) begin
                        st_next.base_vac  = 1'b1;
                        res.command       = CMD_VAC;
                        res.vacuum_target = VAC_BASE;
                    end else if (st.tool_vac) begin
                        st_next.tool_vac  = 1'b0;
                        res.command       = CMD_VAC;
                        res.vacuum_target = VAC_TOOL;
                    end else begin
                        st_next.motion = MV_NONE;
                        res.command    = CMD_PDONE;
                    end
                end else if (!st.lifted &&
                             (!st.tool_vac || (cfg.use_base_vac && st.base_vac))) begin
                    // approach phase
                    if (st.motion == MV_XY) begin
                        st_next.motion = MV_Z;
                        res.command    = CMD_MOVE;
                        res.move_dz    = pos_diff(cfg.pick_z, item.pos_z);
                    end else if (st.motion == MV_Z) begin
                        st_next.motion    = MV_NONE;
                        st_next.tool_vac  = 1'b1;
                        res.command       = CMD_VAC;
                        res.vacuum_target = VAC_TOOL;
                    end else if (st.motion == MV_NONE) begin
                        st_next.base_vac  = 1'b0;
                        res.command       = CMD_VAC;
                        res.vacuum_target = VAC_BASE;
                    end else begin
                        fin       = 1'b1;
                        fin_fault = 1'b1;
                    end
                end else if (!st.lifted && st.tool_vac) begin
                    st_next.lifted = 1'b1;
                    st_next.motion = MV_Z;
                    res.command    = CMD_MOVE;
                    res.move_dz    = LIFT;
                end else if (st.lifted && st.tool_vac) begin
                    st_next.lifted    = 1'b0;
                    st_next.pick_done = 1'b1;
                    st_next.motion    = MV_Z;
                    res.command       = CMD_MOVE;
                    res.move_dz       = -LIFT;
                end
            end
            OP_RESET: begin
                st_next = STATE_CLEAR;
            end
            default: begin
            end
        endcase

        if (fin) begin
            st_next         = STATE_CLEAR;
            res             = '0;
            res.command     = CMD_FIN;
            res.logic_fault = fin_fault;
        end
        res.iterations_done = st_next.iter;
    end

endmodule
